### hw/rtl/qtg_pkg.sv
// Package for the queued tone generator: field widths, command and register codes,
// the beep entry type, the queue control structs and the quarter-wave sine function.
// Depends on nothing; every other file of the block refers to it by scoped names.
package qtg_pkg;

    localparam int PHASE_W    = 24;
    localparam int LEN_W      = 24;
    localparam int DUR_W      = 16;
    localparam int AMP_W      = 15;
    localparam int SPM_W      = 8;
    localparam int SINE_W     = 15;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH_DEF     = 8;
    localparam int SINE_TABLE_BITS_DEF = 8;

    localparam logic [AMP_W-1:0] AMPLITUDE_RESET      = AMP_W'(28000);
    localparam logic [SPM_W-1:0] SAMPLES_PER_MS_RESET = SPM_W'(48);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_MS = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PHASE_W-1:0] step;
        logic [LEN_W-1:0]   length;
    } t_beep;

    typedef struct packed {
        logic push;
        logic tick;
    } t_queue_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // Magnitude of sin(pi/2 * m / 2^(table_bits-2)) in Q0.15, from a Taylor series
    // evaluated in Q30. Only called with constant arguments to build the table.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned m,
                                                       input int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        x  = (64'(m) * HALF_PI_Q30) >> (table_bits - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        return (q > 64'd32767) ? SINE_W'(32767) : q[SINE_W-1:0];
    endfunction

endpackage

### hw/rtl/queued_tone_generator_core.sv
// Top level of the queued tone generator: input register, configuration registers,
// phase accumulator, amplitude multiply and result register.
// Depends on qtg_pkg, qtg_sine_rom and qtg_beep_queue.
//
// Usage: input words (i_command, i_tone_step, i_duration_ms) enter on i_valid/o_ready;
// each produces exactly one result word (o_sample, o_beep_dropped) on o_valid/i_ready.
// An enqueue word stores a beep of i_duration_ms times samples_per_ms samples if that
// is nonzero, returns a zero sample and raises o_beep_dropped if it meets a full queue.
// A tick word returns amplitude times the sine of the phase and advances the phase
// by the front beep's step; with an empty queue it returns zero and the phase holds.
// Configuration words on i_cfg_valid/o_cfg_ready write amplitude (index 0) or
// samples_per_ms (index 1); other indexes are ignored. Write only while idle.
// o_valid rises as a word moves from the input register to the result register; one
// word is taken every cycle while i_ready is high, as the input register feeds one sine
// multiply and the queue update in the same cycle; the sine is read the cycle before.
// When the receiver stalls, the result register holds and the input register still
// takes one more word before o_ready falls. Reset empties the queue, clears the phase
// and restores amplitude 28000 and samples_per_ms 48; it is synchronous to i_clk.
module queued_tone_generator_core #(
    parameter int QUEUE_DEPTH     = qtg_pkg::QUEUE_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = qtg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_command,
    input  logic [qtg_pkg::PHASE_W-1:0]     i_tone_step,
    input  logic [qtg_pkg::DUR_W-1:0]       i_duration_ms,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [qtg_pkg::SAMPLE_W-1:0] o_sample,
    output logic                            o_beep_dropped,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qtg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qtg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [qtg_pkg::AMP_W-1:0]    r_amplitude;
    logic [qtg_pkg::SPM_W-1:0]    r_samples_per_ms;

    logic                         r_in_valid;
    logic                         r_command;
    logic [qtg_pkg::PHASE_W-1:0]  r_tone_step;
    logic [qtg_pkg::DUR_W-1:0]    r_duration_ms;

    logic                         r_out_valid;
    logic [qtg_pkg::SAMPLE_W-1:0] r_sample;
    logic                         r_dropped;
    logic [qtg_pkg::SAMPLE_W-1:0] n_sample;
    logic                         n_dropped;

    logic [qtg_pkg::PHASE_W-1:0]  r_phase;
    logic [qtg_pkg::PHASE_W-1:0]  n_phase;

    logic                         w_fire;
    logic                         w_in_ready;
    logic                         w_enqueue;
    logic [qtg_pkg::LEN_W-1:0]    w_len;
    logic [qtg_pkg::AMP_W+qtg_pkg::SINE_W-1:0] w_prod;
    logic [qtg_pkg::SAMPLE_W-1:0] w_mag;
    logic [qtg_pkg::SINE_W-1:0]   w_sine_mag;
    logic                         w_sine_neg;
    logic [qtg_pkg::PHASE_W-1:0]  w_front_step;
    qtg_pkg::t_queue_cmd          w_qcmd;
    qtg_pkg::t_queue_status       w_qstat;
    qtg_pkg::t_beep               w_beep;

    assign w_fire     = r_in_valid && (!r_out_valid || i_ready);
    assign w_in_ready = !r_in_valid || w_fire;
    assign w_enqueue  = (r_command == qtg_pkg::CMD_ENQUEUE);
    assign w_len      = qtg_pkg::LEN_W'(r_duration_ms * r_samples_per_ms);

    assign w_qcmd.push  = w_fire && w_enqueue && (w_len != '0);
    assign w_qcmd.tick  = w_fire && !w_enqueue;
    assign w_beep.step   = r_tone_step;
    assign w_beep.length = w_len;

    assign w_prod = r_amplitude * w_sine_mag;
    assign w_mag  = {1'b0, w_prod[qtg_pkg::AMP_W+qtg_pkg::SINE_W-1 -: qtg_pkg::AMP_W]};

    always_comb begin
        n_sample  = '0;
        n_dropped = 1'b0;
        n_phase   = r_phase;
        if (w_enqueue) begin
            n_dropped = (w_len != '0) && w_qstat.full;
        end else if (!w_qstat.empty) begin
            n_sample = w_sine_neg ? ('0 - w_mag) : w_mag;
            if (w_fire) begin
                n_phase = r_phase + w_front_step;
            end
        end
    end

    qtg_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_phase (n_phase),
        .o_mag   (w_sine_mag),
        .o_neg   (w_sine_neg)
    );

    qtg_beep_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_beep_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_qcmd),
        .i_beep       (w_beep),
        .o_status     (w_qstat),
        .o_front_step (w_front_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude      <= qtg_pkg::AMPLITUDE_RESET;
            r_samples_per_ms <= qtg_pkg::SAMPLES_PER_MS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qtg_pkg::REG_AMPLITUDE: begin
                    r_amplitude <= i_cfg_data[qtg_pkg::AMP_W-1:0];
                end
                qtg_pkg::REG_SAMPLES_PER_MS: begin
                    r_samples_per_ms <= i_cfg_data[qtg_pkg::SPM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_valid) begin
            r_command     <= i_command;
            r_tone_step   <= i_tone_step;
            r_duration_ms <= i_duration_ms;
        end
        if (w_fire) begin
            r_sample  <= n_sample;
            r_dropped <= n_dropped;
        end
    end

    assign o_ready        = w_in_ready;
    assign o_valid        = r_out_valid;
    assign o_sample       = r_sample;
    assign o_beep_dropped = r_dropped;
    assign o_cfg_ready    = 1'b1;

    a_dropped_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beep_dropped) |-> (o_sample == '0))
        else $error("Dropped beep word carries a nonzero sample.");

    a_phase_holds_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.empty |=> $stable(r_phase))
        else $error("Phase moved while the beep queue was empty.");

    a_full_enqueue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qcmd.push && w_qstat.full) |=> (r_out_valid && r_dropped))
        else $error("Enqueue into a full queue did not raise the drop flag.");

endmodule

### hw/rtl/qtg_sine_rom.sv
// Registered sine lookup for the queued tone generator: quarter-wave constant table
// addressed by the top bits of the phase, with quadrant folding and a sign output.
// Depends on qtg_pkg for widths and the quarter_sine table function.
module qtg_sine_rom #(
    parameter int SINE_TABLE_BITS = qtg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [qtg_pkg::PHASE_W-1:0]  i_phase,
    output logic [qtg_pkg::SINE_W-1:0]   o_mag,
    output logic                         o_neg
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int MW      = SINE_TABLE_BITS - 1;

    logic [qtg_pkg::SINE_W-1:0] w_tab [QUARTER+1];
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [MW-1:0]              w_r;
    logic [MW-1:0]              w_m;
    logic [qtg_pkg::SINE_W-1:0] r_mag;
    logic                       r_neg;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
        assign w_tab[k] = qtg_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end

    assign w_idx = i_phase[qtg_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
    assign w_r   = {1'b0, w_idx[SINE_TABLE_BITS-3:0]};
    assign w_m   = w_idx[SINE_TABLE_BITS-2] ? (MW'(QUARTER) - w_r) : w_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
            r_neg <= 1'b0;
        end else begin
            r_mag <= w_tab[w_m];
            r_neg <= w_idx[SINE_TABLE_BITS-1];
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

### hw/rtl/qtg_beep_queue.sv
// Beep queue for the queued tone generator: a shifting FIFO of step and length entries
// with the remaining-sample counter of the front beep.
// Depends on qtg_pkg for the entry type and the control structs.
module qtg_beep_queue #(
    parameter int QUEUE_DEPTH = qtg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qtg_pkg::t_queue_cmd          i_cmd,
    input  qtg_pkg::t_beep               i_beep,
    output qtg_pkg::t_queue_status       o_status,
    output logic [qtg_pkg::PHASE_W-1:0]  o_front_step
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    qtg_pkg::t_beep            r_q [QUEUE_DEPTH];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [qtg_pkg::LEN_W-1:0] r_rem;
    logic [qtg_pkg::LEN_W-1:0] n_rem;
    logic [qtg_pkg::LEN_W-1:0] w_rem_dec;
    logic                      w_empty;
    logic                      w_full;
    logic                      w_push;
    logic                      w_tick;
    logic                      w_pop;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CW'(QUEUE_DEPTH));
    assign w_push    = i_cmd.push && !w_full;
    assign w_tick    = i_cmd.tick && !w_empty;
    assign w_rem_dec = (r_rem != '0) ? (r_rem - 1'b1) : r_rem;
    assign w_pop     = w_tick && (w_rem_dec == '0);

    always_comb begin
        n_count = r_count;
        n_rem   = r_rem;
        if (w_push) begin
            n_count = r_count + 1'b1;
            if (w_empty) begin
                n_rem = i_beep.length;
            end
        end else if (w_tick) begin
            n_rem = w_rem_dec;
            if (w_pop) begin
                n_count = r_count - 1'b1;
                if (r_count > CW'(1)) begin
                    n_rem = r_q[1].length;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rem   <= '0;
        end else begin
            r_count <= n_count;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
        if (w_push) begin
            r_q[r_count[IW-1:0]] <= i_beep;
        end
    end

    assign o_status.empty = w_empty;
    assign o_status.full  = w_full;
    assign o_front_step   = r_q[0].step;

endmodule
